### src/hrfw_pkg.sv
// shared types and constants of the hex record flash writer
`default_nettype none
package hrfw_pkg;

    localparam int MAX_RECORD_BYTES = 260;
    localparam int BUF_AW           = $clog2(MAX_RECORD_BYTES);
    localparam int CNT_W            = 9;
    localparam logic [CNT_W-1:0] RECV_LIMIT = 9'd511;

    // fixed protected word ranges
    localparam logic [31:0] VEC_LIMIT   = 32'h0000_0004;
    localparam logic [31:0] CFG_LO_WORD = 32'h00F8_0000;
    localparam logic [31:0] CFG_HI_WORD = 32'h00F8_0016;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ELA  = 8'h04;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CSUM   = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    // result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // configuration register indexes
    localparam logic CFG_BOOT_START = 1'b0;
    localparam logic CFG_FLASH_END  = 1'b1;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [30:0] word_address;
        logic [31:0] write_data;
        logic [1:0]  status;
        logic        end_of_record;
    } t_out_item;

    // sequencer commands to the address unit
    typedef struct packed {
        logic        load;
        logic        step;
        logic [30:0] start;
    } t_au_ctrl;

endpackage
`default_nettype wire

### src/hrfw_rec_buf.sv
// record byte buffer with registered read
`default_nettype none
module hrfw_rec_buf (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [hrfw_pkg::BUF_AW-1:0] i_waddr,
    input  wire logic [7:0]                 i_wdata,
    input  wire logic [hrfw_pkg::BUF_AW-1:0] i_raddr,
    output logic      [7:0]                 o_rdata
);
    import hrfw_pkg::*;

    logic [7:0] r_mem [0:MAX_RECORD_BYTES-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/hrfw_addr_unit.sv
// running word address with protected range compare
`default_nettype none
module hrfw_addr_unit (
    input  wire logic               i_clk,
    input  wire hrfw_pkg::t_au_ctrl i_ctrl,
    input  wire logic [23:0]        i_boot_start,
    input  wire logic [23:0]        i_flash_end,
    output logic      [30:0]        o_addr,
    output logic                    o_prot
);
    import hrfw_pkg::*;

    logic [31:0] r_addr;
    logic        in_boot;
    logic        in_vec;
    logic        in_cfg;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_addr <= {1'b0, i_ctrl.start};
        end else if (i_ctrl.step) begin
            r_addr <= r_addr + 32'd2;
        end
    end

    // full 32-bit compares, output masked to 31 bits
    assign in_vec  = r_addr < VEC_LIMIT;
    assign in_boot = (r_addr >= {8'd0, i_boot_start}) && (r_addr <= {8'd0, i_flash_end});
    assign in_cfg  = (r_addr >= CFG_LO_WORD) && (r_addr <= CFG_HI_WORD);
    assign o_prot  = in_vec || in_boot || in_cfg;
    assign o_addr  = r_addr[30:0];

endmodule
`default_nettype wire

### src/hex_record_flash_writer_unit.sv
// top level of the hex record flash writer: collector, sequencer, output register
//
// input channel: one binary hex record byte per transaction, count byte first,
// last_byte set on the checksum byte. bytes are taken one per cycle while the
// block collects; o_in_stall is low only then.
// after the last byte the sequencer walks the record buffer through its single
// registered read port: header checks (RD0 to RD3, TYPE), then for each dword of
// a data record the byte reads (DATA), a wait (DWAIT) and the issue (EMIT), or
// the upper address load of a type 4 record (UP0 to UP2), then the status (STAT).
// output channel: zero or more dword write transactions (kind 0) followed by
// exactly one status transaction (kind 1, end_of_record set). dwords that fall
// in the reset vector, boot range or configuration range give no transaction.
// the result sits in an output register; when the receiver stalls it holds
// and the sequencer waits, collection of the next record resumes after the
// status transaction is loaded.
// reset clears the byte count, sum, upper address, configuration registers
// and the output valid; buffer contents are left as they are.
// configuration writes are taken at any cycle through i_cfg_we.
`default_nettype none
module hex_record_flash_writer_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire hrfw_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output hrfw_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [23:0]         i_cfg_wdata
);
    import hrfw_pkg::*;

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_RD0     = 4'd1;
    localparam logic [3:0] S_RD1     = 4'd2;
    localparam logic [3:0] S_RD2     = 4'd3;
    localparam logic [3:0] S_RD3     = 4'd4;
    localparam logic [3:0] S_TYPE    = 4'd5;
    localparam logic [3:0] S_UP0     = 4'd6;
    localparam logic [3:0] S_UP1     = 4'd7;
    localparam logic [3:0] S_UP2     = 4'd8;
    localparam logic [3:0] S_DATA    = 4'd9;
    localparam logic [3:0] S_DWAIT   = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;
    localparam logic [3:0] S_STAT    = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [7:0]        r_sum;
    logic [CNT_W-1:0]  r_total;
    logic [7:0]        r_fsum;
    logic [15:0]       r_upper;
    logic [23:0]       r_boot_start;
    logic [23:0]       r_flash_end;
    logic [7:0]        r_cnt;
    logic [7:0]        r_hi;
    logic [7:0]        r_lo;
    logic [1:0]        r_status;
    logic [BUF_AW-1:0] r_rd_ptr;
    logic [1:0]        r_phase;
    logic [5:0]        r_dw_left;
    logic              r_rd_vld;
    logic [31:0]       r_word;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_acc;
    logic [CNT_W-1:0]  count_inc;
    logic              buf_we;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]        rdata;
    logic [CNT_W-1:0]  need;
    logic              out_free;
    t_au_ctrl          au_ctrl;
    logic [30:0]       au_addr;
    logic              au_prot;
    logic [31:0]       full_addr;

    assign o_in_stall  = (r_state != S_COLLECT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign count_inc   = (r_count < RECV_LIMIT) ? r_count + 9'd1 : r_count;
    assign buf_we      = in_acc && (r_count < CNT_W'(MAX_RECORD_BYTES));
    assign need        = {1'b0, r_cnt} + 9'd5;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign full_addr   = {r_upper, r_hi, r_lo};

    // header and data read address
    always_comb begin
        unique case (r_state)
            S_RD0:   rd_addr = BUF_AW'(0);
            S_RD1:   rd_addr = BUF_AW'(1);
            S_RD2:   rd_addr = BUF_AW'(2);
            S_RD3:   rd_addr = BUF_AW'(3);
            S_UP0:   rd_addr = BUF_AW'(4);
            S_UP1:   rd_addr = BUF_AW'(5);
            default: rd_addr = r_rd_ptr;
        endcase
    end

    hrfw_rec_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_count[BUF_AW-1:0]),
        .i_wdata (i_in.record_byte),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    hrfw_addr_unit u_addr (
        .i_clk        (i_clk),
        .i_ctrl       (au_ctrl),
        .i_boot_start (r_boot_start),
        .i_flash_end  (r_flash_end),
        .o_addr       (au_addr),
        .o_prot       (au_prot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (in_acc && i_in.last_byte) n_state = S_RD0;
            end
            S_RD0: begin
                n_state = (r_fsum != 8'd0) ? S_STAT : S_RD1;
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                // short record or record too long for the buffer
                if (r_total < need || need > CNT_W'(MAX_RECORD_BYTES)) n_state = S_STAT;
                else n_state = S_RD3;
            end
            S_RD3: n_state = S_TYPE;
            S_TYPE: begin
                if (rdata == REC_DATA && r_cnt >= 8'd2 && r_cnt[1:0] == 2'd0) begin
                    n_state = S_DATA;
                end else if (rdata == REC_ELA && r_cnt >= 8'd2) begin
                    n_state = S_UP0;
                end else begin
                    n_state = S_STAT;
                end
            end
            S_UP0: n_state = S_UP1;
            S_UP1: n_state = S_UP2;
            S_UP2: n_state = S_STAT;
            S_DATA: begin
                if (r_phase == 2'd3) n_state = S_DWAIT;
            end
            S_DWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (au_prot || out_free) begin
                    n_state = (r_dw_left == 6'd1) ? S_STAT : S_DATA;
                end
            end
            S_STAT: begin
                if (out_free) n_state = S_COLLECT;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    // address unit commands
    always_comb begin
        au_ctrl.load  = (r_state == S_TYPE);
        au_ctrl.start = full_addr[31:1];
        au_ctrl.step  = (r_state == S_EMIT) && (au_prot || out_free);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_COLLECT;
            r_count      <= '0;
            r_sum        <= '0;
            r_upper      <= '0;
            r_boot_start <= '0;
            r_flash_end  <= '0;
            r_out_valid  <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_DATA);
            if (in_acc) begin
                if (i_in.last_byte) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= count_inc;
                    r_sum   <= r_sum + i_in.record_byte;
                end
            end
            if (r_state == S_UP2) begin
                r_upper <= {r_hi, rdata};
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BOOT_START: r_boot_start <= i_cfg_wdata;
                    CFG_FLASH_END:  r_flash_end  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if ((r_state == S_EMIT && !au_prot && out_free) ||
                (r_state == S_STAT && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // record datapath
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_byte) begin
            r_total  <= count_inc;
            r_fsum   <= r_sum + i_in.record_byte;
            r_status <= ST_OK;
        end
        case (r_state)
            S_RD0: begin
                if (r_fsum != 8'd0) r_status <= ST_CSUM;
            end
            S_RD1: r_cnt <= rdata;
            S_RD2: begin
                r_hi <= rdata;
                if (r_total < need || need > CNT_W'(MAX_RECORD_BYTES)) r_status <= ST_FORMAT;
            end
            S_RD3: r_lo <= rdata;
            S_TYPE: begin
                r_rd_ptr  <= BUF_AW'(4);
                r_phase   <= 2'd0;
                r_dw_left <= r_cnt[7:2];
                if (rdata == REC_DATA) begin
                    if (r_cnt >= 8'd2 && r_cnt[1:0] != 2'd0) r_status <= ST_FORMAT;
                end else if (rdata == REC_ELA) begin
                    if (r_cnt < 8'd2) r_status <= ST_FORMAT;
                end else if (rdata != REC_EOF) begin
                    r_status <= ST_FORMAT;
                end
            end
            S_UP1: r_hi <= rdata;
            S_DATA: begin
                r_rd_ptr <= r_rd_ptr + BUF_AW'(1);
                r_phase  <= r_phase + 2'd1;
            end
            S_EMIT: begin
                if (au_prot || out_free) r_dw_left <= r_dw_left - 6'd1;
            end
            default: ;
        endcase
        // first byte read ends up least significant
        if (r_rd_vld) begin
            r_word <= {rdata, r_word[31:8]};
        end
        if (r_state == S_EMIT && !au_prot && out_free) begin
            r_out.kind          <= KIND_WRITE;
            r_out.word_address  <= au_addr;
            r_out.write_data    <= r_word;
            r_out.status        <= ST_OK;
            r_out.end_of_record <= 1'b0;
        end else if (r_state == S_STAT && out_free) begin
            r_out.kind          <= KIND_STATUS;
            r_out.word_address  <= '0;
            r_out.write_data    <= '0;
            r_out.status        <= r_status;
            r_out.end_of_record <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    // byte count and sum restart as soon as a record ends
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last_byte) |=> (r_count == '0 && r_sum == 8'd0 && r_state == S_RD0))
        else $error("record end did not restart collection");

    // no bytes counted while the record is being processed
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COLLECT) |-> (r_count == '0))
        else $error("byte count moved during processing");

    // a dword is in flight only while some remain
    a_dw_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA || r_state == S_DWAIT || r_state == S_EMIT) |-> (r_dw_left != 6'd0))
        else $error("dword loop ran past the record");
`endif

endmodule
`default_nettype wire
